/* hw/rtl/mpsm_pkg.sv */
// shared types, constants and helpers of the multi-pattern string matcher
`timescale 1ns / 1ps

package mpsm_pkg;

  localparam int MaxNodesDef      = 256;
  localparam int MaxPatternsDef   = 64;
  localparam int PositionWidthDef = 32;

  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_BUILD   = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_FULL  = 1'b1
  } kind_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] symbol;
    logic       pattern_end;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  pattern_id;
    logic [31:0] start_position;
    logic        last_of_run;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_ERR,
    ST_P_GOTO, ST_P_RDT, ST_P_LINK, ST_P_LINK2,
    ST_B_RR, ST_B_RV, ST_B_POP, ST_B_U, ST_B_UF, ST_B_CR, ST_B_CV,
    ST_B_T, ST_B_TV, ST_B_TF,
    ST_T_RD, ST_T_RV, ST_T_F, ST_T_N, ST_T_H, ST_T_P, ST_T_PV, ST_T_END
  } state_e;

  // ascii upper case to lower case
  function automatic logic [7:0] fold_symbol(input logic [7:0] s);
    logic [7:0] r;
    r = s;
    if (s >= 8'h41 && s <= 8'h5A) begin
      r = s + 8'h20;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/multi_pattern_string_matcher.sv */
// top level of the multi-pattern string matcher (aho-corasick, case folded)
`timescale 1ns / 1ps

// usage
//   input channel in_valid_i / in_stall_o / in_beat_i: one beat per command,
//   pattern characters build the trie, a build beat computes failure links
//   and restarts the scan, text characters are matched
//   output channel out_valid_o / out_stall_i / out_beat_o: one beat per
//   match (id, start position) or one error beat when a store is full;
//   last_of_run marks the final beat caused by an input beat
// processing
//   one beat is worked on at a time; in_stall_o is high while busy
//   pattern character: a goto read, then a new node if needed; a pattern
//   end also reads the node's list tail and links the pattern in
//   text character: goto / failure walk, then the output chain of the
//   reached node, each node's pattern list read and its matches reported
//   build: each symbol of each queued node is read, failure walk per child
// reset
//   a clearing pass empties all MAX_NODES*256 entries of the goto memory,
//   the input stalls meanwhile
// back pressure
//   a held output beat stalls the sequencer whenever a buffered match or an
//   error beat must be handed over; the next input is taken while a beat waits
module multi_pattern_string_matcher
  import mpsm_pkg::*;
#(
  parameter int MAX_NODES      = MaxNodesDef,
  parameter int MAX_PATTERNS   = MaxPatternsDef,
  parameter int POSITION_WIDTH = PositionWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int GAW   = NW + 8;
  localparam int GD    = MAX_NODES * 256;
  localparam int PCW   = $clog2(MAX_PATTERNS + 1);
  localparam int PIW   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int POSW  = POSITION_WIDTH;

  localparam logic [NW:0]    NodeLim = (NW + 1)'(MAX_NODES);
  localparam logic [PCW-1:0] PatLim  = PCW'(MAX_PATTERNS);

  // memories: goto trie, per-node failure link / output list head and tail,
  // per-pattern next-on-node link and length, breadth-first queue
  logic [NW:0]     gmem [GD];
  logic [NW-1:0]   fmem [MAX_NODES];
  logic [PCW-1:0]  hmem [MAX_NODES];
  logic [PCW-1:0]  tmem [MAX_NODES];
  logic [PCW-1:0]  nmem [MAX_PATTERNS];
  logic [7:0]      lmem [MAX_PATTERNS];
  logic [NW-1:0]   qmem [MAX_NODES];

  logic [GAW-1:0]  ga;
  logic [NW-1:0]   na;
  logic [PIW-1:0]  pa;
  logic [NW-1:0]   qa;
  logic [NW:0]     gd_q;
  logic [NW-1:0]   fd_q, qd_q;
  logic [PCW-1:0]  hd_q, td_q, nd_q;
  logic [7:0]      ld_q;

  logic            g_we, f_we, h_we, t_we, n_we, l_we, q_we;
  logic [GAW-1:0]  g_wa;
  logic [NW:0]     g_wd;
  logic [NW-1:0]   f_wa, f_wd, ht_wa, q_wd;
  logic [PCW-1:0]  h_wd, t_wd, n_wd;
  logic [PIW-1:0]  n_wa, l_wa;
  logic [7:0]      ld_wd;

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[g_wa] <= g_wd;
    end
    gd_q <= gmem[ga];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fmem[f_wa] <= f_wd;
    end
    if (h_we) begin
      hmem[ht_wa] <= h_wd;
    end
    if (t_we) begin
      tmem[ht_wa] <= t_wd;
    end
    fd_q <= fmem[na];
    hd_q <= hmem[na];
    td_q <= tmem[na];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      nmem[n_wa] <= n_wd;
    end
    if (l_we) begin
      lmem[l_wa] <= ld_wd;
    end
    nd_q <= nmem[pa];
    ld_q <= lmem[pa];
  end

  // control registers
  state_e          state_q, state_d;
  logic [GAW-1:0]  clr_q, clr_d;
  logic [NW:0]     node_cnt_q, node_cnt_d;
  logic [PCW-1:0]  pat_cnt_q, pat_cnt_d;
  logic [NW-1:0]   ins_q, ins_d;
  logic [7:0]      len_q, len_d;
  logic [NW-1:0]   scan_q, scan_d;
  logic [POSW-1:0] pos_q, pos_d;
  logic [7:0]      sym_q, sym_d;
  logic            end_q, end_d;
  logic [NW-1:0]   cur_q, cur_d;
  logic [PCW-1:0]  tl_q, tl_d;
  logic [7:0]      c_q, c_d;
  logic [NW-1:0]   qh_q, qh_d, qt_q, qt_d;
  logic [NW-1:0]   u_q, u_d, v_q, v_d, t_q, t_d, tf_q, tf_d;
  logic [PCW-1:0]  p_q, p_d;
  logic            pend_v_q, pend_v_d;
  out_beat_t       pend_q, pend_d;
  logic            out_v_q, out_v_d;
  out_beat_t       out_q, out_d;

  logic            emit_v;
  out_beat_t       emit;
  logic            slot_free;
  logic [NW:0]     gm1;
  logic [PCW-1:0]  pm1;
  logic [POSW-1:0] start;
  out_beat_t       hit;

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[qt_q] <= q_wd;
    end
    qd_q <= qmem[qa];
  end

  assign gm1       = gd_q - 1'b1;
  assign pm1       = p_q - 1'b1;
  assign pa        = PIW'(pm1);
  assign slot_free = !out_v_q || !out_stall_i;
  assign start     = pos_q - POSW'(ld_q) + 1'b1;

  always_comb begin
    hit                = '0;
    hit.kind           = KIND_MATCH;
    hit.pattern_id     = 6'(pa);
    hit.start_position = 32'(start);
    hit.last_of_run    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      node_cnt_q <= (NW + 1)'(1);
      pat_cnt_q  <= '0;
      ins_q      <= '0;
      len_q      <= '0;
      scan_q     <= '0;
      pos_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      node_cnt_q <= node_cnt_d;
      pat_cnt_q  <= pat_cnt_d;
      ins_q      <= ins_d;
      len_q      <= len_d;
      scan_q     <= scan_d;
      pos_q      <= pos_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    end_q  <= end_d;
    cur_q  <= cur_d;
    tl_q   <= tl_d;
    c_q    <= c_d;
    qh_q   <= qh_d;
    qt_q   <= qt_d;
    u_q    <= u_d;
    v_q    <= v_d;
    t_q    <= t_d;
    tf_q   <= tf_d;
    p_q    <= p_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // output register
  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (emit_v) begin
      out_v_d = 1'b1;
      out_d   = emit;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_beat_o  = out_q;
  assign in_stall_o  = (state_q != ST_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    node_cnt_d = node_cnt_q;
    pat_cnt_d  = pat_cnt_q;
    ins_d      = ins_q;
    len_d      = len_q;
    scan_d     = scan_q;
    pos_d      = pos_q;
    sym_d      = sym_q;
    end_d      = end_q;
    cur_d      = cur_q;
    tl_d       = tl_q;
    c_d        = c_q;
    qh_d       = qh_q;
    qt_d       = qt_q;
    u_d        = u_q;
    v_d        = v_q;
    t_d        = t_q;
    tf_d       = tf_q;
    p_d        = p_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    emit_v     = 1'b0;
    emit       = pend_q;
    ga         = {ins_q, sym_q};
    na         = t_q;
    qa         = qh_q;
    g_we = 1'b0; g_wa = clr_q;      g_wd = '0;
    f_we = 1'b0; f_wa = v_q;        f_wd = '0;
    h_we = 1'b0; t_we = 1'b0;       ht_wa = cur_q;
    h_wd = '0;   t_wd = '0;
    n_we = 1'b0; n_wa = PIW'(pat_cnt_q); n_wd = '0;
    l_we = 1'b0; l_wa = PIW'(pat_cnt_q); ld_wd = len_q;
    q_we = 1'b0; q_wd = v_q;

    unique case (state_q)
      ST_CLEAR: begin
        g_we  = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == GAW'(GD - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        sym_d = fold_symbol(in_beat_i.symbol);
        end_d = in_beat_i.pattern_end;
        ga    = {ins_q, fold_symbol(in_beat_i.symbol)};
        if (in_valid_i) begin
          unique case (in_beat_i.command)
            CMD_PATTERN: begin
              if (in_beat_i.pattern_end && pat_cnt_q >= PatLim) begin
                ins_d   = '0;
                len_d   = '0;
                state_d = ST_ERR;
              end else begin
                state_d = ST_P_GOTO;
              end
            end
            CMD_BUILD: begin
              c_d     = '0;
              qh_d    = '0;
              qt_d    = '0;
              state_d = ST_B_RR;
            end
            CMD_TEXT: state_d = ST_T_RD;
            default: ;
          endcase
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          emit_v = 1'b1;
          emit   = '{kind: KIND_FULL, pattern_id: '0, start_position: '0,
                     last_of_run: 1'b1};
          state_d = ST_IDLE;
        end
      end

      // pattern character
      ST_P_GOTO: begin
        if (gd_q == '0) begin
          if (node_cnt_q >= NodeLim) begin
            if (end_q) begin
              ins_d = '0;
              len_d = '0;
            end
            state_d = ST_ERR;
          end else begin
            g_we       = 1'b1;
            g_wa       = {ins_q, sym_q};
            g_wd       = node_cnt_q + 1'b1;
            f_we       = 1'b1;
            f_wa       = node_cnt_q[NW-1:0];
            h_we       = 1'b1;
            t_we       = 1'b1;
            ht_wa      = node_cnt_q[NW-1:0];
            node_cnt_d = node_cnt_q + 1'b1;
            cur_d      = node_cnt_q[NW-1:0];
            ins_d      = node_cnt_q[NW-1:0];
            if (len_q != 8'hFF) begin
              len_d = len_q + 1'b1;
            end
            state_d = end_q ? ST_P_RDT : ST_IDLE;
          end
        end else begin
          cur_d = gm1[NW-1:0];
          ins_d = gm1[NW-1:0];
          if (len_q != 8'hFF) begin
            len_d = len_q + 1'b1;
          end
          state_d = end_q ? ST_P_RDT : ST_IDLE;
        end
      end

      ST_P_RDT: begin
        na      = cur_q;
        state_d = ST_P_LINK;
      end

      ST_P_LINK: begin
        l_we      = 1'b1;
        n_we      = 1'b1;
        t_we      = 1'b1;
        t_wd      = pat_cnt_q + 1'b1;
        pat_cnt_d = pat_cnt_q + 1'b1;
        ins_d     = '0;
        len_d     = '0;
        if (td_q != '0) begin
          tl_d    = td_q;
          state_d = ST_P_LINK2;
        end else begin
          h_we    = 1'b1;
          h_wd    = pat_cnt_q + 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_P_LINK2: begin
        n_we    = 1'b1;
        n_wa    = PIW'(tl_q - 1'b1);
        n_wd    = pat_cnt_q;
        state_d = ST_IDLE;
      end

      // build: children of the root
      ST_B_RR: begin
        ga      = {NW'(0), c_q};
        state_d = ST_B_RV;
      end

      ST_B_RV: begin
        if (gd_q != '0) begin
          f_we = 1'b1;
          f_wa = gm1[NW-1:0];
          q_we = 1'b1;
          q_wd = gm1[NW-1:0];
          qt_d = qt_q + 1'b1;
        end
        c_d     = c_q + 1'b1;
        state_d = (c_q == 8'hFF) ? ST_B_POP : ST_B_RR;
      end

      // build: breadth-first walk
      ST_B_POP: begin
        if (qh_q == qt_q) begin
          scan_d  = '0;
          pos_d   = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_B_U;
        end
      end

      ST_B_U: begin
        u_d     = qd_q;
        qh_d    = qh_q + 1'b1;
        na      = qd_q;
        state_d = ST_B_UF;
      end

      ST_B_UF: begin
        tf_d    = fd_q;
        c_d     = '0;
        state_d = ST_B_CR;
      end

      ST_B_CR: begin
        ga      = {u_q, c_q};
        state_d = ST_B_CV;
      end

      ST_B_CV: begin
        if (gd_q == '0) begin
          c_d     = c_q + 1'b1;
          state_d = (c_q == 8'hFF) ? ST_B_POP : ST_B_CR;
        end else begin
          v_d     = gm1[NW-1:0];
          t_d     = tf_q;
          state_d = ST_B_T;
        end
      end

      ST_B_T: begin
        ga      = {t_q, c_q};
        state_d = ST_B_TV;
      end

      ST_B_TV: begin
        if (gd_q != '0 || t_q == '0) begin
          f_we    = 1'b1;
          f_wd    = (gd_q != '0) ? gm1[NW-1:0] : '0;
          q_we    = 1'b1;
          qt_d    = qt_q + 1'b1;
          c_d     = c_q + 1'b1;
          state_d = (c_q == 8'hFF) ? ST_B_POP : ST_B_CR;
        end else begin
          na      = t_q;
          state_d = ST_B_TF;
        end
      end

      ST_B_TF: begin
        t_d     = fd_q;
        state_d = ST_B_T;
      end

      // text character: goto / failure walk
      ST_T_RD: begin
        ga      = {scan_q, sym_q};
        state_d = ST_T_RV;
      end

      ST_T_RV: begin
        if (gd_q != '0) begin
          scan_d  = gm1[NW-1:0];
          t_d     = gm1[NW-1:0];
          state_d = ST_T_N;
        end else if (scan_q != '0) begin
          na      = scan_q;
          state_d = ST_T_F;
        end else begin
          t_d     = '0;
          state_d = ST_T_N;
        end
      end

      ST_T_F: begin
        scan_d  = fd_q;
        state_d = ST_T_RD;
      end

      // text character: output chain
      ST_T_N: begin
        na      = t_q;
        state_d = (t_q == '0) ? ST_T_END : ST_T_H;
      end

      ST_T_H: begin
        p_d     = hd_q;
        tf_d    = fd_q;
        state_d = ST_T_P;
      end

      ST_T_P: begin
        if (p_q == '0) begin
          t_d     = tf_q;
          state_d = ST_T_N;
        end else begin
          state_d = ST_T_PV;
        end
      end

      ST_T_PV: begin
        if (!pend_v_q || slot_free) begin
          emit_v   = pend_v_q;
          pend_v_d = 1'b1;
          pend_d   = hit;
          p_d      = nd_q;
          state_d  = ST_T_P;
        end
      end

      ST_T_END: begin
        if (!pend_v_q) begin
          pos_d   = pos_q + 1'b1;
          state_d = ST_IDLE;
        end else if (slot_free) begin
          emit_v           = 1'b1;
          emit.last_of_run = 1'b1;
          pend_v_d         = 1'b0;
          pos_d            = pos_q + 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* tb/sv/multi_pattern_string_matcher_tb.sv */
// self-checking testbench of the multi-pattern string matcher
`timescale 1ns / 1ps

module multi_pattern_string_matcher_tb;
  import mpsm_pkg::*;

  localparam int NodeCap    = MaxNodesDef;
  localparam int PatCap     = MaxPatternsDef;
  localparam int ResultCap  = 64;
  localparam int QuietLimit = 1000000;

  // trie, failure links and output chains kept alongside the block
  class match_scoreboard;
    int unsigned child [NodeCap][256];   // node + 1, zero means no edge
    int unsigned fail_of [NodeCap];
    int unsigned head_of [NodeCap];      // pattern id + 1, zero means none
    int unsigned tail_of [NodeCap];
    int unsigned next_pat [PatCap];
    int unsigned pat_len [PatCap];
    int unsigned nodes, pats, ins_node, ins_len, scan;
    bit [31:0]   text_pos;
    out_beat_t   pending [$];
    int          errors, shown, beats_in, beats_out, full_beats, match_beats;

    function new();
      foreach (child[n, s]) child[n][s] = 0;
      foreach (fail_of[n]) begin
        fail_of[n] = 0;
        head_of[n] = 0;
        tail_of[n] = 0;
      end
      nodes    = 1;
      pats     = 0;
      ins_node = 0;
      ins_len  = 0;
      scan     = 0;
      text_pos = '0;
    endfunction

    function void push_full();
      out_beat_t e;
      e = '{kind: KIND_FULL, pattern_id: '0, start_position: '0, last_of_run: 1'b1};
      pending.insert(pending.size(), e);
    endfunction

    // breadth-first failure link computation, restarts the scan
    function void build_links();
      int unsigned q [$];
      int unsigned u, v, t, w, g;
      for (int c = 0; c < 256; c++) begin
        v = child[0][c];
        if (v != 0) begin
          fail_of[v-1] = 0;
          q.insert(q.size(), v - 1);
        end
      end
      while (q.size() > 0) begin
        u = q.pop_front();
        for (int c = 0; c < 256; c++) begin
          v = child[u][c];
          if (v == 0) continue;
          t = fail_of[u];
          g = 0;
          while (t != 0 && child[t][c] == 0 && g < NodeCap) begin
            t = fail_of[t];
            g++;
          end
          w = child[t][c];
          fail_of[v-1] = (w != 0) ? w - 1 : 0;
          q.insert(q.size(), v - 1);
        end
      end
      scan     = 0;
      text_pos = '0;
    endfunction

    function void note_input(in_beat_t b);
      logic [7:0]  s;
      int unsigned g, n, id, t, p, k, guard, pguard;
      out_beat_t   e;
      beats_in++;
      s = b.symbol;
      if (s >= 8'h41 && s <= 8'h5A) s = s + 8'h20;
      case (b.command)
        CMD_PATTERN: begin
          if (b.pattern_end && pats >= PatCap) begin
            ins_node = 0;
            ins_len  = 0;
            push_full();
            return;
          end
          g = child[ins_node][s];
          if (g == 0) begin
            if (nodes >= NodeCap) begin
              if (b.pattern_end) begin
                ins_node = 0;
                ins_len  = 0;
              end
              push_full();
              return;
            end
            n = nodes++;
            child[ins_node][s] = n + 1;
            fail_of[n] = 0;
            head_of[n] = 0;
            tail_of[n] = 0;
            g = n + 1;
          end
          ins_node = g - 1;
          if (ins_len < 255) ins_len++;
          if (b.pattern_end) begin
            id = pats++;
            pat_len[id]  = ins_len;
            next_pat[id] = 0;
            if (tail_of[ins_node] != 0) next_pat[tail_of[ins_node]-1] = id + 1;
            else head_of[ins_node] = id + 1;
            tail_of[ins_node] = id + 1;
            ins_node = 0;
            ins_len  = 0;
          end
        end
        CMD_BUILD: build_links();
        CMD_TEXT: begin
          guard = 0;
          while (scan != 0 && child[scan][s] == 0 && guard < NodeCap) begin
            scan = fail_of[scan];
            guard++;
          end
          g = child[scan][s];
          scan = (g != 0) ? g - 1 : 0;
          k = 0;
          t = scan;
          guard = 0;
          while (t != 0 && guard < NodeCap) begin
            p = head_of[t];
            pguard = 0;
            while (p != 0 && k < ResultCap && pguard < PatCap) begin
              e.kind           = KIND_MATCH;
              e.pattern_id     = 6'(p - 1);
              e.start_position = text_pos - 32'(pat_len[p-1]) + 32'd1;
              e.last_of_run    = 1'b0;
              pending.insert(pending.size(), e);
              k++;
              p = next_pat[p-1];
              pguard++;
            end
            t = fail_of[t];
            guard++;
          end
          if (k > 0) pending[pending.size()-1].last_of_run = 1'b1;
          text_pos = text_pos + 32'd1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      beats_out++;
      if (got.kind == KIND_FULL) full_beats++;
      else match_beats++;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result beat %p", got);
        end
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.pattern_id !== want.pattern_id ||
          got.start_position !== want.start_position ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '{command: CMD_NONE, symbol: 8'h00, pattern_end: 1'b0};
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  match_scoreboard sb = new();

  bit idle_on = 1'b1;      // random gaps on both sides
  int hold_req = 0;        // long receiver hold-off, in cycles
  int quiet = 0;

  multi_pattern_string_matcher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: every accepted beat is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
  end

  // watchdog over cycles with no beat on either side, covers the clearing pass and builds
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern: random bursts, quiet stretches, one long hold-off
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // one beat, held until taken, with an optional gap before it
  task automatic send_beat(cmd_e c, logic [7:0] s, logic e);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= '{command: c, symbol: s, pattern_end: e};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(in_beat_i);
    @(negedge clk_i);
  endtask

  task automatic send_word(string w);
    for (int i = 0; i < w.len(); i++) send_beat(CMD_PATTERN, w[i], i == w.len() - 1);
  endtask

  task automatic send_text(string w);
    for (int i = 0; i < w.len(); i++) send_beat(CMD_TEXT, w[i], 1'b0);
  endtask

  // sender pause until every expected beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    case ($urandom_range(0, 5))
      0: return "a";
      1: return "b";
      2: return "c";
      3: return "A";
      4: return "B";
      default: return "C";
    endcase
  endfunction

  // a byte with no edge yet from the current insertion node
  function automatic logic [7:0] fresh_symbol();
    for (int c = 0; c < 256; c++) begin
      if ((c < 8'h41 || c > 8'h5A) && sb.child[sb.ins_node][c] == 0) return 8'(c);
    end
    return 8'h00;
  endfunction

  initial begin
    int len;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: text before any build, classic word set with case, extreme bytes
    send_text("he");
    send_word("he");
    send_word("SHE");
    send_word("his");
    send_word("hers");
    send_beat(CMD_PATTERN, 8'h00, 1'b1);
    send_beat(CMD_PATTERN, 8'hFF, 1'b0);
    send_beat(CMD_BUILD, 8'h00, 1'b0);      // build with a pattern still open
    send_beat(CMD_PATTERN, 8'hFF, 1'b1);
    send_beat(CMD_NONE, 8'h5A, 1'b1);       // unused command, no result
    drain();
    send_beat(CMD_BUILD, 8'hFF, 1'b0);
    send_text("uShErS");
    send_beat(CMD_TEXT, 8'h00, 1'b0);
    send_beat(CMD_TEXT, 8'hFF, 1'b0);
    send_beat(CMD_TEXT, 8'hFF, 1'b0);

    // random rounds: a few patterns, a build, then text over a small alphabet
    for (int r = 0; r < 2; r++) begin
      for (int p = 0; p < 8; p++) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) send_beat(CMD_PATTERN, pick_symbol(), i == len - 1);
      end
      drain();
      send_beat(CMD_BUILD, 8'($urandom), 1'($urandom));
      if (r == 1) hold_req = 300;            // block fills up while results wait
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 19) == 0) send_beat(CMD_NONE, 8'($urandom), 1'($urandom));
        else send_beat(CMD_TEXT, pick_symbol(), 1'($urandom));
      end
    end

    // fresh random patterns until the node store is used up, the pattern
    // store runs out on the way
    while (sb.nodes < NodeCap) begin
      len = $urandom_range(2, 4);
      for (int i = 0; i < len; i++) send_beat(CMD_PATTERN, 8'($urandom), i == len - 1);
    end
    // one character past the full node store, one pattern end past the full pattern store
    send_beat(CMD_PATTERN, fresh_symbol(), 1'b0);
    send_beat(CMD_PATTERN, "h", 1'b1);
    drain();

    // last part with no gaps: full-trie build and a final scan
    idle_on = 1'b0;
    send_beat(CMD_BUILD, 8'h00, 1'b0);
    send_text("ahhishersheabcABCcbaHe");

    drain();
    repeat (200) @(negedge clk_i);
    $display("input beats %0d, result beats %0d (%0d matches, %0d store-full)",
             sb.beats_in, sb.beats_out, sb.match_beats, sb.full_beats);
    $display("covered pre-build text, mid-pattern build, node and pattern store exhaustion");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
